[rtl/rfap_pkg.sv]
// shared constants for the tag frame header alignment and parity check
`timescale 1ns / 1ps

package rfap_pkg;

  localparam int FRAME_LEN   = 64;
  localparam int HEADER_BITS = 9;
  localparam int ROW_COUNT   = 10;
  localparam int ROW_STRIDE  = 5;
  localparam int ROT_W       = $clog2(FRAME_LEN);

  // top HEADER_BITS bits set
  localparam logic [FRAME_LEN-1:0] HDR_MASK = ~({FRAME_LEN{1'b1}} >> HEADER_BITS);

  // column parity bits within the lowest group of ROW_STRIDE bits
  localparam logic [ROW_STRIDE-1:0] COLUMN_MASK = 5'h1E;

  typedef logic [FRAME_LEN-1:0] frame_t;

endpackage

[rtl/rfap_in_if.sv]
// input channel carrying one raw captured frame per transaction
`timescale 1ns / 1ps

interface rfap_in_if;
  logic           valid;
  logic           ready;
  rfap_pkg::frame_t frame_in;

  modport source (output valid, output frame_in, input ready);
  modport sink   (input valid, input frame_in, output ready);
endinterface

[rtl/rfap_out_if.sv]
// result channel carrying the aligned frame and its status flags
`timescale 1ns / 1ps

interface rfap_out_if;
  logic             valid;
  logic             ready;
  rfap_pkg::frame_t aligned_frame;
  logic             header_found;
  logic             was_inverted;
  logic             frame_valid;

  modport source (output valid, output aligned_frame, output header_found,
                  output was_inverted, output frame_valid, input ready);
  modport sink   (input valid, input aligned_frame, input header_found,
                  input was_inverted, input frame_valid, output ready);
endinterface

[rtl/rfid_frame_align_parity_check_unit.sv]
// top level: header search by single-bit rotation, then row and column parity check
`timescale 1ns / 1ps

// Takes one raw 64-bit circular tag capture per transaction on in_if and returns
// one result transaction on out_if: the frame rotated so the all-ones header sits
// in the top bits (inverted when only the inverted capture holds a header, and the
// plain inverted capture when neither does), a header found flag, an inverted
// flag, and a frame valid flag that is set only when the header was found and all
// ten row parities and four column parities are even. The search runs on one
// shared rotate-by-one and header compare unit, one rotation per cycle: rotations
// 0..63 of the capture, then rotations 0..63 of its inverse, stopping at the first
// header hit. The parity check follows in the check state, which holds until the
// output register is free. in_if.ready is high only while the unit is idle, one
// capture at a time. The result sits in an output register, so a new capture may
// be accepted while the previous result still waits for out_if.ready. No state
// carries from one transaction to the next, and there is no configuration.
module rfid_frame_align_parity_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  rfap_in_if.sink     in_if,
  rfap_out_if.source  out_if
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_CHECK  = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [rfap_pkg::ROT_W-1:0] rot_cnt_r, rot_cnt_nxt;
  logic                       pass_r, pass_nxt;      // 1 during the inverted pass
  logic                       found_r, found_nxt;
  rfap_pkg::frame_t           word_r, word_nxt;

  logic                       out_valid_r, out_valid_nxt;
  rfap_pkg::frame_t           out_frame_r;
  logic                       out_found_r;
  logic                       out_inv_r;
  logic                       out_ok_r;

  // shared unit: header compare and rotate left by one
  logic                       hdr_hit;
  rfap_pkg::frame_t           word_rot;

  // parity check of the held word
  logic [rfap_pkg::ROW_STRIDE-1:0] col_acc;
  logic                            rows_ok;
  logic                            parity_ok;

  logic in_fire;
  logic out_fire;
  logic load_out;

  assign hdr_hit  = (word_r & rfap_pkg::HDR_MASK) == rfap_pkg::HDR_MASK;
  assign word_rot = {word_r[rfap_pkg::FRAME_LEN-2:0], word_r[rfap_pkg::FRAME_LEN-1]};

  // each row is data bits over an even parity bit, so the five bits xor to zero
  always_comb begin
    col_acc = '0;
    rows_ok = 1'b1;
    for (int k = 0; k < rfap_pkg::ROW_COUNT; k++) begin
      col_acc = col_acc ^ word_r[rfap_pkg::ROW_STRIDE*(k+1) +: rfap_pkg::ROW_STRIDE];
      if (^word_r[rfap_pkg::ROW_STRIDE*(k+1) +: rfap_pkg::ROW_STRIDE]) begin
        rows_ok = 1'b0;
      end
    end
  end

  assign parity_ok = rows_ok &&
                     ((col_acc & rfap_pkg::COLUMN_MASK) ==
                      (word_r[rfap_pkg::ROW_STRIDE-1:0] & rfap_pkg::COLUMN_MASK));

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_valid_r && out_if.ready;
  // result moves to the output register once the previous one is gone
  assign load_out = (state_r == ST_CHECK) && (!out_valid_r || out_if.ready);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    rot_cnt_nxt = rot_cnt_r;
    pass_nxt    = pass_r;
    found_nxt   = found_r;
    word_nxt    = word_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          word_nxt    = in_if.frame_in;
          rot_cnt_nxt = '0;
          pass_nxt    = 1'b0;
          found_nxt   = 1'b0;
          state_nxt   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hdr_hit) begin
          found_nxt = 1'b1;
          state_nxt = ST_CHECK;
        end else if (rot_cnt_r == rfap_pkg::ROT_W'(rfap_pkg::FRAME_LEN - 1)) begin
          // full turn done, word_rot is the pass start word again
          word_nxt    = ~word_rot;
          rot_cnt_nxt = '0;
          if (pass_r) begin
            // no header in either polarity, word holds the inverted capture
            word_nxt  = word_rot;
            state_nxt = ST_CHECK;
          end else begin
            pass_nxt = 1'b1;
          end
        end else begin
          word_nxt    = word_rot;
          rot_cnt_nxt = rot_cnt_r + 1'b1;
        end
      end
      ST_CHECK: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath and result payload, no reset needed
  always_ff @(posedge clk) begin
    rot_cnt_r <= rot_cnt_nxt;
    pass_r    <= pass_nxt;
    found_r   <= found_nxt;
    word_r    <= word_nxt;
    if (load_out) begin
      out_frame_r <= word_r;
      out_found_r <= found_r;
      out_inv_r   <= pass_r;
      out_ok_r    <= found_r && parity_ok;
    end
  end

  assign in_if.ready          = (state_r == ST_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.aligned_frame = out_frame_r;
  assign out_if.header_found  = out_found_r;
  assign out_if.was_inverted  = out_inv_r;
  assign out_if.frame_valid   = out_ok_r;

`ifndef SYNTHESIS
  a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SEARCH) && (rot_cnt_r == '0) && !pass_r)
    else $error("accepted transaction did not start a fresh search");

  a_missing_header_means_inverted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> out_inv_r)
    else $error("header missing without the inverted pass");

  a_valid_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ok_r) |-> out_found_r)
    else $error("frame valid without a header");

  a_header_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |->
      ((out_frame_r & rfap_pkg::HDR_MASK) == rfap_pkg::HDR_MASK))
    else $error("reported header not in the top bits");

  a_result_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && out_valid_r && !out_if.ready) |=> (state_r == ST_CHECK))
    else $error("check state left while the previous result was pending");
`endif

endmodule

[test/tb_rfid_frame_align_parity_check_unit.sv]
// testbench for the tag frame header alignment and parity check unit
`timescale 1ns / 1ps

module tb_rfid_frame_align_parity_check_unit;

  // run length and limits
  localparam int RANDOM_PER_PHASE = 610;
  localparam int RX_HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES     = 140;   // slightly above the worst search latency
  localparam int CYCLE_LIMIT      = 2_000_000;

  // one result transaction as the unit should produce it
  typedef struct packed {
    rfap_pkg::frame_t aligned_frame;
    logic             header_found;
    logic             was_inverted;
    logic             frame_valid;
  } tag_result_t;

  // one directed capture; when has_answer is set the answer is typed in by hand
  typedef struct packed {
    rfap_pkg::frame_t raw;
    logic             has_answer;
    tag_result_t      answer;
  } directed_row_t;

  localparam int NUM_DIRECTED = 20;

  localparam rfap_pkg::frame_t ONES = {rfap_pkg::FRAME_LEN{1'b1}};

  // directed captures: extremes, header at various phases and wrapped around
  // bit 0, both polarities, row and column parity errors, stop bit either way
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    // all zeros: only the inverted capture holds a header, rows fail parity
    '{64'h0000_0000_0000_0000, 1'b1, '{ONES, 1'b1, 1'b1, 1'b0}},
    // all ones: header at rotation 0, rows fail parity
    '{ONES, 1'b1, '{ONES, 1'b1, 1'b0, 1'b0}},
    // alternating bits: no header in either polarity
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
      '{64'h5555_5555_5555_5555, 1'b0, 1'b1, 1'b0}},
    '{64'h5555_5555_5555_5555, 1'b1,
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b0}},
    // clean frame with all-zero data, stop bit low and high
    '{64'hFF80_0000_0000_0000, 1'b1, '{64'hFF80_0000_0000_0000, 1'b1, 1'b0, 1'b1}},
    '{64'hFF80_0000_0000_0001, 1'b1, '{64'hFF80_0000_0000_0001, 1'b1, 1'b0, 1'b1}},
    // same frame captured at other phases
    '{64'h0000_0000_0000_01FF, 1'b1, '{64'hFF80_0000_0000_0000, 1'b1, 1'b0, 1'b1}},
    '{64'h0FF8_0000_0000_0000, 1'b1, '{64'hFF80_0000_0000_0000, 1'b1, 1'b0, 1'b1}},
    // row 0 parity bit set over zero data
    '{64'hFF80_0000_0000_0020, 1'b1, '{64'hFF80_0000_0000_0020, 1'b1, 1'b0, 1'b0}},
    // column parity bit set with all rows zero
    '{64'hFF80_0000_0000_0002, 1'b1, '{64'hFF80_0000_0000_0002, 1'b1, 1'b0, 1'b0}},
    // one data bit in row 0 with matching row and column parity
    '{64'hFF80_0000_0000_0062, 1'b1, '{64'hFF80_0000_0000_0062, 1'b1, 1'b0, 1'b1}},
    // single set bit: header found in the inverted capture, one rotation in for the top bit
    '{64'h8000_0000_0000_0000, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 1'b0}},
    '{64'h0000_0000_0000_0001, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 1'b0}},
    // eight ones only: one short of a header, found in the inverted capture
    '{64'hFF00_0000_0000_0000, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b1, 1'b0}},
    // left to the predictor
    '{64'h007F_FFFF_FFFF_FF9D, 1'b0, '0},
    '{64'hF000_0000_0000_001F, 1'b0, '0},
    '{64'h0000_0018_8000_0000, 1'b0, '0},
    '{64'h0123_4567_89AB_CDEF, 1'b0, '0},
    '{64'hDEAD_BEEF_CAFE_F00D, 1'b0, '0},
    '{64'h7FC0_0000_0000_0031, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  rfap_in_if  in_ch ();
  rfap_out_if out_ch ();

  rfid_frame_align_parity_check_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  tag_result_t awaited_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 46;
  bit          rx_hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: header search in both polarities, then row and column parity
  // ---------------------------------------------------------------------------
  function automatic tag_result_t align_and_check_frame(rfap_pkg::frame_t raw);
    tag_result_t                     res;
    rfap_pkg::frame_t                word;
    logic [rfap_pkg::ROW_STRIDE-1:0] row;
    logic [rfap_pkg::ROW_STRIDE-1:0] column_sum;
    logic                            hit;
    res  = '0;
    word = raw;
    hit  = 1'b0;
    for (int pass = 0; pass < 2 && !hit; pass++) begin
      // a failed first pass turned the word a full circle, so it is raw again
      if (pass == 1) begin
        word = ~raw;
        res.was_inverted = 1'b1;
      end
      for (int r = 0; r < rfap_pkg::FRAME_LEN && !hit; r++) begin
        if ((word & rfap_pkg::HDR_MASK) == rfap_pkg::HDR_MASK) begin
          hit = 1'b1;
        end else begin
          word = {word[rfap_pkg::FRAME_LEN-2:0], word[rfap_pkg::FRAME_LEN-1]};
        end
      end
    end
    res.aligned_frame = word;
    res.header_found  = hit;
    if (hit) begin
      res.frame_valid = 1'b1;
      column_sum = '0;
      for (int k = 0; k < rfap_pkg::ROW_COUNT; k++) begin
        row = word[rfap_pkg::ROW_STRIDE*(k+1) +: rfap_pkg::ROW_STRIDE];
        if ((^row[4:1]) != row[0]) res.frame_valid = 1'b0;
        column_sum ^= row;
      end
      if ((column_sum & rfap_pkg::COLUMN_MASK) !=
          (word[rfap_pkg::ROW_STRIDE-1:0] & rfap_pkg::COLUMN_MASK))
        res.frame_valid = 1'b0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // capture generation
  // ---------------------------------------------------------------------------
  function automatic rfap_pkg::frame_t rotate_left(rfap_pkg::frame_t f, int unsigned amount);
    return (f << amount) | (f >> (rfap_pkg::FRAME_LEN - amount));
  endfunction

  // well-formed frame: header, ten rows with even parity, column parity, stop bit
  function automatic rfap_pkg::frame_t build_tag_frame(logic [39:0] payload, logic stop);
    rfap_pkg::frame_t f;
    logic [3:0]       nibble;
    logic [3:0]       columns;
    f = rfap_pkg::HDR_MASK;
    columns = '0;
    for (int k = 0; k < rfap_pkg::ROW_COUNT; k++) begin
      nibble = payload[4*k +: 4];
      f[rfap_pkg::ROW_STRIDE*k + 6 +: 4] = nibble;
      f[rfap_pkg::ROW_STRIDE*k + 5]      = ^nibble;
      columns ^= nibble;
    end
    f[4:1] = columns;
    f[0]   = stop;
    return f;
  endfunction

  // mostly real frames at a random phase and polarity, some with bit errors,
  // the rest noise, part of it carrying a run of ones near the header length
  function automatic rfap_pkg::frame_t make_capture();
    rfap_pkg::frame_t f;
    int unsigned      roll;
    int unsigned      flips;
    int unsigned      run_len;
    roll = $urandom_range(99);
    if (roll < 80) begin
      f = build_tag_frame({8'($urandom_range(255)), $urandom()}, 1'($urandom_range(1)));
      if ($urandom_range(1)) f = ~f;
      f = rotate_left(f, $urandom_range(rfap_pkg::FRAME_LEN - 1));
      if (roll >= 60) begin
        flips = $urandom_range(3, 1);
        repeat (flips) f ^= rfap_pkg::frame_t'(1) << $urandom_range(rfap_pkg::FRAME_LEN - 1);
      end
    end else begin
      f = {$urandom(), $urandom()};
      if (roll >= 93) begin
        run_len = $urandom_range(12, 7);
        f |= rotate_left(~(ONES >> run_len), $urandom_range(rfap_pkg::FRAME_LEN - 1));
      end
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: offer one capture, wait for the transaction, log its answer
  // ---------------------------------------------------------------------------
  task automatic offer_capture(rfap_pkg::frame_t raw, logic has_answer,
                               tag_result_t answer);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.frame_in <= raw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    awaited_results.push_back(has_answer ? answer : align_and_check_frame(raw));
  endtask

  task automatic wait_all_results();
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: ready with random gaps, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        // long stall so the unit fills and drops in_if.ready
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result transaction with the oldest awaited one
  always @(posedge clk) begin
    tag_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none awaited, actual frame %h found %b inv %b valid %b",
                 $time, out_ch.aligned_frame, out_ch.header_found,
                 out_ch.was_inverted, out_ch.frame_valid);
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.aligned_frame !== want.aligned_frame) begin
          mismatch_count++;
          $display("%0t: aligned_frame expected %h actual %h",
                   $time, want.aligned_frame, out_ch.aligned_frame);
        end
        if (out_ch.header_found !== want.header_found) begin
          mismatch_count++;
          $display("%0t: header_found expected %b actual %b",
                   $time, want.header_found, out_ch.header_found);
        end
        if (out_ch.was_inverted !== want.was_inverted) begin
          mismatch_count++;
          $display("%0t: was_inverted expected %b actual %b",
                   $time, want.was_inverted, out_ch.was_inverted);
        end
        if (out_ch.frame_valid !== want.frame_valid) begin
          mismatch_count++;
          $display("%0t: frame_valid expected %b actual %b",
                   $time, want.frame_valid, out_ch.frame_valid);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results still awaited", $time, awaited_results.size());
      $display("FAIL rfid_frame_align_parity_check_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.frame_in <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_capture(directed_rows[i].raw, directed_rows[i].has_answer,
                    directed_rows[i].answer);
    end

    // random phases: sender light / receiver heavy idling, then swapped, then none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 10;
          rx_idle_pct = 46;
        end
        1: begin
          tx_idle_pct = 46;
          rx_idle_pct = 10;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // receiver stalls for a long stretch while captures keep coming
        if (n == 50 && phase != 1) rx_hold_req = 1'b1;
        offer_capture(make_capture(), 1'b0, '0);
      end
      // sender pauses between phases until the unit has drained
      in_ch.valid <= 1'b0;
      wait_all_results();
    end

    in_ch.valid <= 1'b0;
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS rfid_frame_align_parity_check_unit");
    end else begin
      $display("FAIL rfid_frame_align_parity_check_unit");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rfap_pkg.sv
rtl/rfap_in_if.sv
rtl/rfap_out_if.sv
rtl/rfid_frame_align_parity_check_unit.sv
test/tb_rfid_frame_align_parity_check_unit.sv
